// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PKTB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PKTB_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define PKTB_ASSERT(label, prop)
`define PKTB_ASSERT_RST(label, prop)
`endif
`endif

// ----- hw/rtl/pktb_pkg.sv -----
// Types and constants of the per-key token bucket limiter.
`default_nettype none
package pktb_pkg;
    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [39:0] tokens;
        logic [47:0] last_ms;
    } way_t;

    localparam logic [1:0] REG_REFILL = 2'd0;
    localparam logic [1:0] REG_BURST  = 2'd1;
    localparam logic [1:0] REG_IDLE   = 2'd2;

    localparam logic [1:0] ST_OFF   = 2'd0;
    localparam logic [1:0] ST_HIT   = 2'd1;
    localparam logic [1:0] ST_NEW   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [39:0] ONE_TOKEN  = 40'd65536;
    localparam logic [39:0] MASK40     = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] IDLE_RESET = 32'd60000;
endpackage
`default_nettype wire

// ----- hw/rtl/per_key_token_bucket_limiter_unit.sv -----
// Top level of the per-key token bucket limiter.
// Requests enter on in_valid/in_stall with client_key, time_ms and cost;
// one result per request leaves on out_valid/out_stall with allowed,
// status and tokens_left. Configuration is written through the APB port
// (refill at 0x00, burst at 0x08, idle limit at 0x10, 64-bit data).
// One request is in work at a time: in_stall stays high from acceptance
// until its result is loaded into the output register. The key is folded
// at acceptance and reduced modulo SETS by a reciprocal multiply (S_MOD)
// and a correction (S_REM); then follow one read of the set's row, lookup,
// two refill stages and one write-back, and S_DONE loads the result into
// the output register. With limiting off a request goes from acceptance
// straight to S_DONE and leaves the table alone. After reset the table is
// cleared one set per cycle with in_stall high. The output register holds
// a stalled result while the next request is taken and worked on; that
// request waits for the register before it finishes.
`default_nettype none
`include "assert_macros.svh"
module per_key_token_bucket_limiter_unit
    import pktb_pkg::*;
#(
    parameter int SETS = 64,
    parameter int WAYS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] client_key,
    input  wire logic [47:0] time_ms,
    input  wire logic [31:0] cost,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             allowed,
    output logic      [1:0]  status,
    output logic      [39:0] tokens_left
);
    localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam int FOLD_W = 27;
    localparam logic [12:0] SETS_C  = 13'(SETS);
    localparam logic [11:0] FOLD_M1 = 12'((64'd1 << 12) % 64'(SETS));
    localparam logic [11:0] FOLD_M2 = 12'((64'd1 << 24) % 64'(SETS));
    localparam logic [11:0] FOLD_M3 = 12'((64'd1 << 36) % 64'(SETS));
    localparam logic [11:0] FOLD_M4 = 12'((64'd1 << 48) % 64'(SETS));
    localparam logic [11:0] FOLD_M5 = 12'((64'd1 << 60) % 64'(SETS));
    localparam logic [31:0] RECIP   = 32'((64'd1 << 31) / 64'(SETS));

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_REM   = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_LOOK  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_CHG   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    typedef way_t [WAYS-1:0] row_t;

    row_t mem [SETS];
    row_t rd_row_reg;
    row_t row_reg, row_next;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [FOLD_W-1:0] fold_reg, fold_next;
    logic [FOLD_W-1:0] q_reg, q_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;

    logic [31:0] refill_reg;
    logic [39:0] burst_reg;
    logic [31:0] idle_reg;

    logic [63:0] key_reg;
    logic [47:0] time_reg;
    logic [31:0] cost_reg;

    logic [WAY_W-1:0] slot_reg, slot_next;
    logic        found_reg, found_next;
    logic        free_reg, free_next;
    logic [39:0] told_reg, told_next;
    logic [47:0] el_reg, el_next;
    logic [63:0] plo_reg;
    logic [39:0] phi_reg;
    logic        sat_reg;
    logic [39:0] tok_reg, tok_next;

    logic        res_allowed_reg, res_allowed_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [39:0] res_tokens_reg, res_tokens_next;

    logic        out_valid_reg, out_valid_next;
    logic        allowed_reg;
    logic [1:0]  status_reg;
    logic [39:0] tokens_left_reg;
    logic        out_load;

    logic cfg_wr;
    logic in_acc;
    logic rd_en;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    row_t wr_data;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign allowed     = allowed_reg;
    assign status      = status_reg;
    assign tokens_left = tokens_left_reg;

    always_comb
    begin
        unique case (paddr[4:3])
            REG_REFILL: prdata = {32'd0, refill_reg};
            REG_BURST:  prdata = {24'd0, burst_reg};
            REG_IDLE:   prdata = {32'd0, idle_reg};
            default:    prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refill_reg <= 32'd0;
            burst_reg  <= ONE_TOKEN;
            idle_reg   <= IDLE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                REG_REFILL: refill_reg <= pwdata[31:0];
                REG_BURST:  burst_reg  <= (pwdata[39:0] < ONE_TOKEN) ? ONE_TOKEN
                                                                     : pwdata[39:0];
                REG_IDLE:   idle_reg   <= pwdata[31:0];
                default:    ;
            endcase
        end
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rem_reg];
        end
    end

    assign rd_en   = (state_reg == S_READ);
    assign wr_en   = (state_reg == S_CLEAR) || (state_reg == S_CHG);
    assign wr_addr = (state_reg == S_CLEAR) ? clr_reg : rem_reg;

    // lookup over the set's row
    always_comb
    begin
        logic        full;
        logic [47:0] el;
        logic [WAYS-1:0] vld;
        full       = 1'b1;
        row_next   = rd_row_reg;
        slot_next  = '0;
        found_next = 1'b0;
        free_next  = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!rd_row_reg[w].valid)
            begin
                full = 1'b0;
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            el = (time_reg > rd_row_reg[w].last_ms) ? time_reg - rd_row_reg[w].last_ms
                                                     : 48'd0;
            vld[w] = rd_row_reg[w].valid && !(full && (el > {16'd0, idle_reg}));
            row_next[w].valid = vld[w];
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!vld[w])
            begin
                slot_next = WAY_W'(w);
                free_next = 1'b1;
            end
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vld[w] && (rd_row_reg[w].key == key_reg))
            begin
                slot_next  = WAY_W'(w);
                found_next = 1'b1;
            end
        end
        told_next = rd_row_reg[slot_next].tokens;
        el_next   = (time_reg > rd_row_reg[slot_next].last_ms)
                  ? time_reg - rd_row_reg[slot_next].last_ms : 48'd0;
    end

    // refill sum
    always_comb
    begin
        logic [72:0] add;
        logic [40:0] sum;
        add = {1'b0, phi_reg, 32'd0} + {9'd0, plo_reg};
        sum = {1'b0, told_reg} + {1'b0, add[39:0]};
        if (!found_reg)
        begin
            tok_next = burst_reg;
        end
        else if (sat_reg || (add > {33'd0, MASK40}))
        begin
            tok_next = burst_reg;
        end
        else if (sum > {1'b0, burst_reg})
        begin
            tok_next = burst_reg;
        end
        else
        begin
            tok_next = sum[39:0];
        end
    end

    // write-back row and result
    always_comb
    begin
        logic [39:0] left;
        logic        pass;
        pass = ({8'd0, cost_reg} <= tok_reg);
        left = pass ? tok_reg - {8'd0, cost_reg} : tok_reg;
        wr_data = '0;
        res_allowed_next = res_allowed_reg;
        res_status_next  = res_status_reg;
        res_tokens_next  = res_tokens_reg;
        if (state_reg == S_CHG)
        begin
            wr_data = row_reg;
            if (found_reg || free_reg)
            begin
                wr_data[slot_reg].valid   = 1'b1;
                wr_data[slot_reg].key     = key_reg;
                wr_data[slot_reg].tokens  = left;
                wr_data[slot_reg].last_ms = time_reg;
                res_allowed_next = pass;
                res_status_next  = found_reg ? ST_HIT : ST_NEW;
                res_tokens_next  = left;
            end
            else
            begin
                res_allowed_next = 1'b1;
                res_status_next  = ST_FULL;
                res_tokens_next  = 40'd0;
            end
        end
        else if (state_reg == S_IDLE)
        begin
            res_allowed_next = 1'b1;
            res_status_next  = ST_OFF;
            res_tokens_next  = 40'd0;
        end
    end

    // fold key, then reduce modulo SETS
    always_comb
    begin
        logic [23:0] p1, p2, p3, p4, p5;
        logic [58:0] qp;
        logic [39:0] qs;
        logic [FOLD_W-1:0] r;
        p1 = {12'd0, client_key[23:12]} * {12'd0, FOLD_M1};
        p2 = {12'd0, client_key[35:24]} * {12'd0, FOLD_M2};
        p3 = {12'd0, client_key[47:36]} * {12'd0, FOLD_M3};
        p4 = {12'd0, client_key[59:48]} * {12'd0, FOLD_M4};
        p5 = {20'd0, client_key[63:60]} * {12'd0, FOLD_M5};
        fold_next = {15'd0, client_key[11:0]} + {3'd0, p1} + {3'd0, p2}
                  + {3'd0, p3} + {3'd0, p4} + {3'd0, p5};
        qp = {32'd0, fold_reg} * {27'd0, RECIP};
        q_next = qp[57:31];
        qs = {13'd0, q_reg} * {27'd0, SETS_C};
        r = fold_reg - qs[FOLD_W-1:0];
        if (r >= {14'd0, SETS_C})
        begin
            r = r - {14'd0, SETS_C};
        end
        rem_next = r[IDX_W-1:0];
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (refill_reg == 32'd0) ? S_DONE : S_MOD;
                end
            end
            S_MOD:   state_next = S_REM;
            S_REM:   state_next = S_READ;
            S_READ:  state_next = S_LOOK;
            S_LOOK:  state_next = S_MUL;
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_CHG;
            S_CHG:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            key_reg  <= client_key;
            time_reg <= time_ms;
            cost_reg <= cost;
            fold_reg <= fold_next;
        end
        if (state_reg == S_MOD)
        begin
            q_reg <= q_next;
        end
        if (state_reg == S_REM)
        begin
            rem_reg <= rem_next;
        end
        if (state_reg == S_LOOK)
        begin
            row_reg   <= row_next;
            slot_reg  <= slot_next;
            found_reg <= found_next;
            free_reg  <= free_next;
            told_reg  <= told_next;
            el_reg    <= el_next;
        end
        if (state_reg == S_MUL)
        begin
            plo_reg <= {32'd0, el_reg[31:0]} * {32'd0, refill_reg};
            phi_reg <= {32'd0, el_reg[39:32]} * {8'd0, refill_reg};
            sat_reg <= |el_reg[47:40];
        end
        if (state_reg == S_SUM)
        begin
            tok_reg <= tok_next;
        end
        res_allowed_reg <= res_allowed_next;
        res_status_reg  <= res_status_next;
        res_tokens_reg  <= res_tokens_next;
        if (out_load)
        begin
            allowed_reg     <= res_allowed_reg;
            status_reg      <= res_status_reg;
            tokens_left_reg <= res_tokens_reg;
        end
    end

    `PKTB_ASSERT_RST(a_clear_stalls, (!rst_n || state_reg == S_CLEAR) |-> in_stall)
    `PKTB_ASSERT(a_accept_busy, in_acc |=> (state_reg != S_IDLE))
    `PKTB_ASSERT(a_full_allows, (out_valid && status == ST_FULL) |-> allowed)
    `PKTB_ASSERT(a_off_empty, (out_valid && status == ST_OFF) |-> (allowed && tokens_left == 40'd0))
endmodule
`default_nettype wire
